// ===== sv/xmi_event_stream_parser_unit_defines.svh =====
// assertion macros for the xmi event parser
`ifndef XMI_EVENT_STREAM_PARSER_UNIT_DEFINES_SVH
`define XMI_EVENT_STREAM_PARSER_UNIT_DEFINES_SVH
// implication checked on every clock unless in reset
`define XMI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication with the consequent checked in the next cycle
`define XMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/xmi_pkg.sv =====
// ----------------------------------------------------------------------------
// xmi_pkg
// types and constants shared by the xmi event parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package xmi_pkg;
  localparam logic [2:0] KIND_CHAN    = 3'd0;
  localparam logic [2:0] KIND_META    = 3'd1;
  localparam logic [2:0] KIND_SYSEX   = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_TEMPO   = 3'd4;
  localparam logic [2:0] KIND_DEFTMP  = 3'd5;
  localparam logic [2:0] KIND_DONE    = 3'd6;
  localparam logic [2:0] KIND_ERROR   = 3'd7;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TRUNC = 2'd1;
  localparam logic [1:0] ERR_BAD   = 2'd2;
  localparam logic [1:0] ERR_LONG  = 2'd3;

  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_CHAN_MAX = 8'hEF;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
  localparam logic [23:0] TEMPO_SAT     = 24'hFFFFFF;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0, PH_DELTA = 4'd1, PH_DATA1 = 4'd2, PH_DATA2 = 4'd3,
    PH_NOTELEN = 4'd4, PH_META_TYPE = 4'd5, PH_META_LEN = 4'd6,
    PH_SYSEX_LEN = 4'd7, PH_PAYLOAD = 4'd8, PH_HALT = 4'd9
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] event_time;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [27:0] payload_length;
    logic [7:0]  payload_value;
    logic [23:0] tempo_value;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // run one parse step on the held item
    logic div_start; // start tempo divide
    logic emit2;     // present second result (done after default tempo)
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] nres;     // results of the step
    logic       need_div; // step ends in tempo conversion
    logic       div_done;
  } dp_stat_t;
endpackage

// ===== sv/xmi_stream_if.sv =====
// ----------------------------------------------------------------------------
// xmi_stream_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface xmi_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/xmi_divider.sv =====
// ----------------------------------------------------------------------------
// xmi_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module xmi_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dsr};
  assign quotient = quo;

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/xmi_datapath.sv =====
// ----------------------------------------------------------------------------
// xmi_datapath
// parse state, result formation and tempo conversion
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module xmi_datapath import xmi_pkg::*; #(
  parameter int QUANTITY_MAX_BYTES = 4,
  parameter int TIME_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  item_t    item,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output result_t  res
);
  // 3 * ceil(2^41 / 25000), exact floor(tempo*3/25000) for every 24-bit tempo
  localparam logic [27:0] PPQN_RECIP = 28'd263882793;

  phase_t               phase;
  logic [TIME_BITS-1:0] cur_t;
  logic [TIME_BITS-1:0] lat_t;
  logic [7:0]           hst;
  logic [15:0]          hdat;
  logic [27:0]          qacc;
  logic [2:0]           qcnt;
  logic [27:0]          prem;
  logic [23:0]          tbuf;
  logic                 tz;
  logic                 fin;
  logic [1:0]           nres;

  phase_t               phase_next;
  logic [TIME_BITS-1:0] cur_next, lat_next;
  logic [7:0]           hst_next;
  logic [15:0]          hdat_next;
  logic [27:0]          qacc_next, prem_next;
  logic [2:0]           qcnt_next;
  logic [23:0]          tbuf_next;
  logic                 tz_next, fin_next;
  result_t              r0, r0_next, r1;
  logic [1:0]           nres_next;
  logic                 div_next;

  logic [7:0]           b;
  logic [27:0]          qfa;
  logic [2:0]           qfc;
  logic [1:0]           qst; // 0 more, 1 done, 2 too long
  logic [TIME_BITS-1:0] tend;
  logic                 need_div;
  logic [51:0]          ppqn_prod;
  logic [31:0]          ppqn;
  logic [31:0]          num;
  logic [31:0]          quo;
  logic                 ddone;
  logic                 dstart;
  logic [23:0]          tv;
  logic                 tv_ok;

  assign b = item.data_byte;
  assign qfc = qcnt + 3'd1;
  assign qfa = {qacc[20:0], b[6:0]};
  assign tend = cur_t + TIME_BITS'(qfa);
  always_comb begin
    if (!b[7]) qst = 2'd1;
    else if (32'(qfc) >= 32'(QUANTITY_MAX_BYTES)) qst = 2'd2;
    else qst = 2'd0;
  end

  function automatic result_t mk(logic [2:0] k, logic [TIME_BITS-1:0] t, logic [7:0] st,
                                 logic [7:0] d1, logic [7:0] d2, logic [27:0] pl,
                                 logic [7:0] pv, logic [23:0] tv, logic [1:0] e);
    result_t r;
    r.kind = k; r.event_time = 32'(t); r.status_byte = st; r.first_data = d1;
    r.second_data = d2; r.payload_length = pl; r.payload_value = pv;
    r.tempo_value = tv; r.error_code = e; r.last_of_run = 1'b0;
    return r;
  endfunction

  // one parse step
  always_comb begin
    phase_next = phase; cur_next = cur_t; lat_next = lat_t; hst_next = hst;
    hdat_next = hdat; qacc_next = qacc; qcnt_next = qcnt; prem_next = prem;
    tbuf_next = tbuf; tz_next = tz; fin_next = fin; nres_next = 2'd0;
    div_next = 1'b0; r0_next = r0;
    if (phase == PH_HALT) begin
      nres_next = 2'd0;
    end else if (item.command) begin
      if (fin || phase == PH_IDLE) begin
        phase_next = PH_HALT;
        if (!tz) begin
          nres_next = 2'd2;
          r0_next = mk(KIND_DEFTMP, '0, ST_META, META_TEMPO, 8'd0, 28'd3, 8'd0,
                       TEMPO_DEFAULT, ERR_NONE);
        end else begin
          nres_next = 2'd1;
          r0_next = mk(KIND_DONE, cur_t, 8'd0, 8'd0, 8'd0, '0, 8'd0, '0, ERR_NONE);
        end
      end else begin
        nres_next = 2'd1; phase_next = PH_HALT;
        r0_next = mk(KIND_ERROR, cur_t, 8'd0, 8'd0, 8'd0, '0, 8'd0, '0, ERR_TRUNC);
      end
    end else if (!fin) begin
      case (phase)
        PH_IDLE, PH_DELTA: begin
          if (!b[7]) begin
            cur_next = cur_t + TIME_BITS'(b);
            phase_next = PH_DELTA;
          end else begin
            if (cur_t > lat_t) lat_next = cur_t;
            hst_next = b; hdat_next = '0;
            if (b == ST_META) phase_next = PH_META_TYPE;
            else if (b == ST_SYSEX) begin
              qacc_next = '0; qcnt_next = '0; phase_next = PH_SYSEX_LEN;
            end else if (b <= ST_CHAN_MAX) phase_next = PH_DATA1;
            else begin
              nres_next = 2'd1; phase_next = PH_HALT;
              r0_next = mk(KIND_ERROR, cur_t, b, 8'd0, 8'd0, '0, 8'd0, '0, ERR_BAD);
            end
          end
        end
        PH_DATA1: begin
          hdat_next = {8'd0, b};
          if (hst[7:4] == 4'hC || hst[7:4] == 4'hD) begin
            nres_next = 2'd1; phase_next = PH_IDLE;
            r0_next = mk(KIND_CHAN, cur_t, hst, b, 8'd0, '0, 8'd0, '0, ERR_NONE);
          end else phase_next = PH_DATA2;
        end
        PH_DATA2: begin
          nres_next = 2'd1;
          r0_next = mk(KIND_CHAN, cur_t, hst, hdat[7:0], b, '0, 8'd0, '0, ERR_NONE);
          hdat_next = {b, hdat[7:0]};
          if (hst[7:4] == 4'h9) begin
            qacc_next = '0; qcnt_next = '0; phase_next = PH_NOTELEN;
          end else phase_next = PH_IDLE;
        end
        PH_NOTELEN: begin
          qacc_next = qfa; qcnt_next = qfc;
          if (qst == 2'd2) begin
            nres_next = 2'd1; phase_next = PH_HALT;
            r0_next = mk(KIND_ERROR, cur_t, 8'd0, 8'd0, 8'd0, '0, 8'd0, '0, ERR_LONG);
          end else if (qst == 2'd1) begin
            if (tend > lat_t) lat_next = tend;
            nres_next = 2'd1; phase_next = PH_IDLE;
            r0_next = mk(KIND_CHAN, tend, hst, hdat[7:0], 8'd0, '0, 8'd0, '0, ERR_NONE);
          end
        end
        PH_META_TYPE: begin
          hdat_next = {8'd0, b};
          if (b == META_EOT) begin
            if (cur_t < lat_t) cur_next = lat_t;
            nres_next = 2'd1; fin_next = 1'b1; phase_next = PH_IDLE;
            r0_next = mk(KIND_META, (cur_t < lat_t) ? lat_t : cur_t, ST_META, META_EOT,
                         8'd0, '0, 8'd0, '0, ERR_NONE);
          end else begin
            qacc_next = '0; qcnt_next = '0; phase_next = PH_META_LEN;
          end
        end
        PH_META_LEN, PH_SYSEX_LEN: begin
          qacc_next = qfa; qcnt_next = qfc;
          if (qst == 2'd2) begin
            nres_next = 2'd1; phase_next = PH_HALT;
            r0_next = mk(KIND_ERROR, cur_t, 8'd0, 8'd0, 8'd0, '0, 8'd0, '0, ERR_LONG);
          end else if (qst == 2'd1) begin
            prem_next = qfa; tbuf_next = '0; nres_next = 2'd1;
            if (phase == PH_META_LEN)
              r0_next = mk(KIND_META, cur_t, ST_META, hdat[7:0], 8'd0, qfa, 8'd0, '0,
                           ERR_NONE);
            else
              r0_next = mk(KIND_SYSEX, cur_t, ST_SYSEX, 8'd0, 8'd0, qfa, 8'd0, '0,
                           ERR_NONE);
            phase_next = (qfa == '0) ? PH_IDLE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          prem_next = prem - 28'd1;
          if (hst == ST_META && hdat[7:0] == META_TEMPO && qacc == 28'd3) begin
            tbuf_next = {tbuf[15:0], b};
            if (prem == 28'd1) begin
              if (cur_t == '0) tz_next = 1'b1;
              div_next = 1'b1; nres_next = 2'd1; phase_next = PH_IDLE;
              r0_next = mk(KIND_TEMPO, cur_t, ST_META, META_TEMPO, 8'd0, 28'd3, 8'd0,
                           '0, ERR_NONE);
            end
          end else begin
            nres_next = 2'd1;
            r0_next = mk(KIND_PAYLOAD, cur_t, hst, (hst == ST_META) ? hdat[7:0] : 8'd0,
                         8'd0, qacc, b, '0, ERR_NONE);
            if (prem == 28'd1) phase_next = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; cur_t <= '0; lat_t <= '0; hst <= '0; hdat <= '0;
      qacc <= '0; qcnt <= '0; prem <= '0; tbuf <= '0; tz <= 1'b0; fin <= 1'b0;
      need_div <= 1'b0; nres <= '0;
    end else if (cmd.load) begin
      phase <= phase_next; cur_t <= cur_next; lat_t <= lat_next; hst <= hst_next;
      hdat <= hdat_next; qacc <= qacc_next; qcnt <= qcnt_next; prem <= prem_next;
      tbuf <= tbuf_next; tz <= tz_next; fin <= fin_next;
      need_div <= div_next; nres <= nres_next; r0 <= r0_next;
    end
  end

  // tempo conversion: ppqn = tbuf*3/25000 by reciprocal multiply, then tbuf*60/ppqn
  assign ppqn_prod = 52'(tbuf) * 52'(PPQN_RECIP);
  assign ppqn = {21'd0, ppqn_prod[51:41]};
  assign num = {8'd0, tbuf} * 32'd60;
  assign dstart = cmd.div_start && ppqn != '0;

  xmi_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(num), .divisor(ppqn),
    .done(ddone), .quotient(quo)
  );

  // converted tempo, saturated on a zero divisor
  always_ff @(posedge clk) begin
    if (rst) tv_ok <= 1'b0;
    else if (cmd.div_start) begin
      tv_ok <= (ppqn == '0); tv <= TEMPO_SAT;
    end else if (ddone) begin
      tv_ok <= 1'b1; tv <= quo[23:0];
    end
  end

  assign stat.nres = nres;
  assign stat.need_div = need_div;
  assign stat.div_done = tv_ok;

  // result selection
  assign r1 = mk(KIND_DONE, cur_t, 8'd0, 8'd0, 8'd0, '0, 8'd0, '0, ERR_NONE);
  always_comb begin
    res = cmd.emit2 ? r1 : r0;
    if (!cmd.emit2 && r0.kind == KIND_TEMPO) res.tempo_value = tv;
    res.last_of_run = cmd.emit2 || nres == 2'd1;
  end
endmodule

// ===== sv/xmi_ctrl.sv =====
// ----------------------------------------------------------------------------
// xmi_ctrl
// sequencer for accept, parse, divide and result delivery
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module xmi_ctrl import xmi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     take,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_STEP = 5'b00010, S_DIV = 5'b00100,
    S_OUT0 = 5'b01000, S_OUT1 = 5'b10000
  } state_t;
  state_t state, state_next;

  assign in_ready = (state == S_IDLE);
  assign take = in_valid && in_ready;
  assign out_valid = (state == S_OUT0) || (state == S_OUT1);

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.emit2 = (state == S_OUT1);
    case (state)
      S_IDLE: if (take) state_next = S_STEP;
      S_STEP: begin
        cmd.load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.nres == 2'd0) state_next = S_IDLE;
        else if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_OUT0;
        end else state_next = S_OUT0;
      end
      S_OUT0: if (out_ready && (!stat.need_div || stat.div_done))
        state_next = (stat.nres == 2'd2) ? S_OUT1 : S_IDLE;
      S_OUT1: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ===== sv/xmi_event_stream_parser_unit.sv =====
// an accepted item passes S_STEP, then S_DIV, before its first result is offered
// a new item is taken only after every result of the last one has been delivered
// tempo conversion runs one serial divide after a reciprocal multiply
// rst is synchronous, clears parse state and the sequencer
// ----------------------------------------------------------------------------
// xmi_event_stream_parser_unit
// xmi event body parser, byte stream in, midi events out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module xmi_event_stream_parser_unit import xmi_pkg::*; #(
  parameter int QUANTITY_MAX_BYTES = 4,
  parameter int TIME_BITS = 32
) (
  input logic clk,
  input logic rst,
  xmi_stream_if.sink   in_ch,
  xmi_stream_if.source out_ch
);
  item_t    item;
  logic     take;
  logic     ov;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;

  // input item register
  always_ff @(posedge clk) begin
    if (take) item <= item_t'(in_ch.data[8:0]);
  end

  xmi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(ov), .out_ready(out_ch.ready), .take(take), .cmd(cmd), .stat(stat)
  );

  xmi_datapath #(.QUANTITY_MAX_BYTES(QUANTITY_MAX_BYTES), .TIME_BITS(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .stat(stat), .res(res)
  );

  // hold off valid while the tempo divide runs
  assign out_ch.valid = ov && !(res.kind == KIND_TEMPO && !cmd.emit2 && !stat.div_done);
  assign out_ch.data = res;
endmodule

// ===== sv/xmi_checker.sv =====
// ----------------------------------------------------------------------------
// xmi_checker
// port-level checks on the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xmi_event_stream_parser_unit_defines.svh"
module xmi_checker import xmi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);
  `XMI_ASSERT_IMP(a_no_overlap, clk, rst, in_ready, !out_valid, "input taken while output pending")
  `XMI_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `XMI_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "second item taken")
endmodule

bind xmi_event_stream_parser_unit xmi_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
